// ===== rtl/conv3x3_zero_pad_filter_defines.svh =====
// Assertion macros for the 3x3 zero-padded filter.
// Needs nothing else; taken in by the files that assert.
`ifndef CONV3X3_ZERO_PAD_FILTER_DEFINES_SVH
`define CONV3X3_ZERO_PAD_FILTER_DEFINES_SVH

// Same-cycle implication, off during reset
`define C3ZP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define C3ZP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/c3zp_pkg.sv =====
// Shared widths, codes, defaults and helpers for the 3x3 zero-padded filter.
// No dependencies.
package c3zp_pkg;

  localparam int unsigned PIXEL_W    = 8;
  localparam int unsigned DIM_W      = 11;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 11;

  localparam int unsigned MAX_WIDTH_DEF      = 1024;
  localparam int unsigned MAX_HEIGHT_DEF     = 1024;
  localparam int unsigned COEF_FRAC_BITS_DEF = 16;

  localparam logic [DIM_W-1:0] DIM_RESET = 11'd1024;

  // Filter modes
  localparam logic [MODE_W-1:0] MODE_GAUSS    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCHARR_H = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SCHARR_V = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  // Gaussian weights in millionths
  localparam longint unsigned GAUSS_MICRO_CORNER = 77847;
  localparam longint unsigned GAUSS_MICRO_EDGE   = 123317;
  localparam longint unsigned GAUSS_MICRO_CENTRE = 195346;
  localparam longint unsigned MICRO_SCALE        = 1000000;

  // Window padding flags for the centre pixel, plus frame end
  typedef struct packed {
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
    logic last;
  } pos_flags_t;

  // Zero acts as one, values above the maximum act as the maximum
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
    logic [DIM_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = 11'd1;
    end else if (32'(v) > maxv) begin
      res = DIM_W'(maxv);
    end
    return res;
  endfunction

endpackage

// ===== rtl/c3zp_intf.sv =====
// Valid/ready channel interfaces of the 3x3 zero-padded filter.
// Depends on c3zp_pkg for payload widths.
interface c3zp_pixel_if;
  logic                            valid;
  logic                            ready;
  logic [c3zp_pkg::PIXEL_W-1:0]    pixel;
  logic                            flush;
  modport source (output valid, pixel, flush, input ready);
  modport sink   (input valid, pixel, flush, output ready);
endinterface

interface c3zp_result_if;
  logic                            valid;
  logic                            ready;
  logic [c3zp_pkg::PIXEL_W-1:0]    out_pixel;
  logic                            last_of_frame;
  modport source (output valid, out_pixel, last_of_frame, input ready);
  modport sink   (input valid, out_pixel, last_of_frame, output ready);
endinterface

interface c3zp_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [c3zp_pkg::CFG_IDX_W-1:0]    index;
  logic [c3zp_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/conv3x3_zero_pad_filter.sv =====
// Top level of the 3x3 zero-padded filter: line store, window, filter arithmetic.
// Depends on c3zp_pkg, the interfaces in c3zp_intf.sv and the assertion macros.
//
// Usage:
// - pixels carries grey pixels of a frame in raster order; flush items drain the
//   block. After the last pixel of a frame send image_width+1 flush items. A flush
//   inside the frame is dropped; a pixel sent during the drain counts as a flush.
// - results carries one filtered pixel per centre position; last_of_frame marks
//   the bottom-right pixel, after which the next frame starts at row zero.
// - cfg writes filter_mode, image_width and image_height (index 0, 1, 2); it is
//   always ready. Writing a dimension restarts the frame. Write only when idle.
// - Throughput: one item per cycle while not stalled, set by the line store, which
//   does one read and one write per cycle; a same-column read right after a write
//   is forwarded. Stages: line read, window, partial sums, output; a result follows
//   the item completing its window, image_width+1 items after its centre pixel.
// - Reset: mode Gaussian, 1024 x 1024, frame position zero, pipeline empty. The
//   line store is not cleared; rows not yet written are always padded out.
// - Receiver stall: the output register holds; the three stages behind it keep
//   filling, and pixels.ready drops once all of them are full.
`include "conv3x3_zero_pad_filter_defines.svh"

module conv3x3_zero_pad_filter #(
  parameter int unsigned MAX_WIDTH      = c3zp_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT     = c3zp_pkg::MAX_HEIGHT_DEF,
  parameter int unsigned COEF_FRAC_BITS = c3zp_pkg::COEF_FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  c3zp_cfg_if.sink     cfg,
  c3zp_pixel_if.sink   pixels,
  c3zp_result_if.source results
);

  localparam int unsigned PW     = c3zp_pkg::PIXEL_W;
  localparam int unsigned DW     = c3zp_pkg::DIM_W;
  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned ACC_W  = COEF_FRAC_BITS + 10;

  localparam logic [ACC_W-1:0] W_CORNER = ACC_W'(
    ((c3zp_pkg::GAUSS_MICRO_CORNER << COEF_FRAC_BITS) + c3zp_pkg::MICRO_SCALE / 2)
    / c3zp_pkg::MICRO_SCALE);
  localparam logic [ACC_W-1:0] W_EDGE = ACC_W'(
    ((c3zp_pkg::GAUSS_MICRO_EDGE << COEF_FRAC_BITS) + c3zp_pkg::MICRO_SCALE / 2)
    / c3zp_pkg::MICRO_SCALE);
  localparam logic [ACC_W-1:0] W_CENTRE = ACC_W'(
    ((c3zp_pkg::GAUSS_MICRO_CENTRE << COEF_FRAC_BITS) + c3zp_pkg::MICRO_SCALE / 2)
    / c3zp_pkg::MICRO_SCALE);
  localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);

  // Configuration registers
  logic [c3zp_pkg::MODE_W-1:0] filter_mode;
  logic [DW-1:0]               image_width;
  logic [DW-1:0]               image_height;
  logic [DW-1:0]               dim_w;
  logic [DW-1:0]               dim_h;
  logic                        cfg_wr;
  logic                        dim_wr;

  // Frame position
  logic [DW-1:0]               in_row;
  logic [DW-1:0]               in_col;
  logic [DW-1:0]               row_next;
  logic [DW-1:0]               col_next;
  logic [DW-1:0]               col_inc;

  // Input decode
  logic                        in_acc;
  logic                        pos_real;
  logic                        in_drop;
  logic [PW-1:0]               in_pix;
  logic                        col_nz;
  logic                        pos_emit;
  c3zp_pkg::pos_flags_t        pos_flags;
  logic [ADDR_W-1:0]           line_addr;

  // Stage enables
  logic                        out_en;
  logic                        s3_en;
  logic                        s2_en;
  logic                        s1_en;
  logic                        s1_adv;

  // Line store and stage 1
  logic [2*PW-1:0]             line_mem [MAX_WIDTH];
  logic [2*PW-1:0]             line_rd;
  logic [2*PW-1:0]             line_word;
  logic [2*PW-1:0]             line_wr_data;
  logic [2*PW-1:0]             byp_word;
  logic                        byp_hit;
  logic [PW-1:0]               line_top;
  logic [PW-1:0]               line_mid;
  logic                        s1_valid;
  logic                        s1_emit;
  logic [PW-1:0]               s1_pix;
  logic [ADDR_W-1:0]           s1_addr;
  c3zp_pkg::pos_flags_t        s1_flags;

  // Window stage
  logic                        s2_valid;
  logic [PW-1:0]               win [9];
  logic [PW-1:0]               win_m [9];
  c3zp_pkg::pos_flags_t        s2_flags;

  // Partial sums stage
  logic [9:0]                  sum_corner;
  logic [9:0]                  sum_edge;
  logic signed [10:0]          sum_a;
  logic signed [9:0]           sum_b;
  logic                        s3_valid;
  logic [9:0]                  s3_corner;
  logic [9:0]                  s3_edge;
  logic [PW-1:0]               s3_centre;
  logic signed [10:0]          s3_a;
  logic signed [9:0]           s3_b;
  logic                        s3_last;

  // Output stage
  logic signed [12:0]          sa_x;
  logic signed [12:0]          sb_x;
  logic signed [12:0]          ssum;
  logic [PW-1:0]               scharr_pix;
  logic [ACC_W-1:0]            gsum;
  logic [9:0]                  gq;
  logic [PW-1:0]               gauss_pix;
  logic [PW-1:0]               res_pix;
  logic                        out_valid;
  logic [PW-1:0]               out_pixel;
  logic                        out_last;

  // ---------------------------------------------------------------- config
  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid && cfg.ready;
  assign dim_wr    = cfg_wr && (cfg.index == c3zp_pkg::CFG_WIDTH ||
                                cfg.index == c3zp_pkg::CFG_HEIGHT);
  assign dim_w     = c3zp_pkg::clamp_dim(image_width, MAX_WIDTH);
  assign dim_h     = c3zp_pkg::clamp_dim(image_height, MAX_HEIGHT);

  // Store register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      filter_mode  <= c3zp_pkg::MODE_GAUSS;
      image_width  <= c3zp_pkg::DIM_RESET;
      image_height <= c3zp_pkg::DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        c3zp_pkg::CFG_MODE:   filter_mode  <= cfg.data[c3zp_pkg::MODE_W-1:0];
        c3zp_pkg::CFG_WIDTH:  image_width  <= cfg.data;
        c3zp_pkg::CFG_HEIGHT: image_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- input decode
  assign in_acc    = pixels.valid && pixels.ready;
  assign pos_real  = in_row < dim_h;
  assign in_drop   = pos_real && pixels.flush;
  assign in_pix    = pos_real ? pixels.pixel : '0;
  assign col_nz    = in_col != '0;
  assign pos_emit  = (in_row >= 11'd2) || (in_row == 11'd1 && col_nz);
  assign line_addr = ADDR_W'(in_col);

  // Padding flags of the centre that this item completes
  always_comb begin
    pos_flags.top_ok   = col_nz ? (in_row >= 11'd2) : (in_row >= 11'd3);
    pos_flags.bot_ok   = col_nz ? (in_row < dim_h) : (in_row <= dim_h);
    pos_flags.left_ok  = (in_col >= 11'd2) || (!col_nz && dim_w >= 11'd2);
    pos_flags.right_ok = col_nz;
    pos_flags.last     = !col_nz && ({1'b0, in_row} == {1'b0, dim_h} + 12'd1);
  end

  // Advance the raster position, wrap at row end, restart after the last output
  always_comb begin
    col_inc  = in_col + 11'd1;
    row_next = in_row;
    col_next = col_inc;
    if (pos_flags.last) begin
      row_next = '0;
      col_next = '0;
    end else if (col_inc >= dim_w) begin
      row_next = in_row + 11'd1;
      col_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || dim_wr) begin
      in_row <= '0;
      in_col <= '0;
    end else if (in_acc && !in_drop) begin
      in_row <= row_next;
      in_col <= col_next;
    end
  end

  // ---------------------------------------------------------------- stage enables
  assign out_en       = !out_valid || results.ready;
  assign s3_en        = !s3_valid || out_en;
  assign s2_en        = !s2_valid || s3_en;
  assign s1_en        = !s1_valid || s2_en;
  assign s1_adv       = s1_valid && s2_en;
  assign pixels.ready = s1_en;

  // ---------------------------------------------------------------- line store
  // Forward the word written in the same cycle as this item's read
  assign line_word    = byp_hit ? byp_word : line_rd;
  assign line_top     = line_word[2*PW-1:PW];
  assign line_mid     = line_word[PW-1:0];
  assign line_wr_data = {line_mid, s1_pix};

  always_ff @(posedge clk) begin
    if (in_acc) begin
      line_rd <= line_mem[line_addr];
    end
    if (s1_adv) begin
      line_mem[s1_addr] <= line_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      byp_hit  <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid <= in_acc && !in_drop;
      end
      if (in_acc) begin
        byp_hit <= s1_adv && (s1_addr == line_addr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pix   <= in_pix;
      s1_addr  <= line_addr;
      s1_emit  <= pos_emit;
      s1_flags <= pos_flags;
      byp_word <= line_wr_data;
    end
  end

  // ---------------------------------------------------------------- window
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  // Shift the window left by one column, new column from the line store and pixel
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win[0]   <= win[1];
      win[1]   <= win[2];
      win[2]   <= line_top;
      win[3]   <= win[4];
      win[4]   <= win[5];
      win[5]   <= line_mid;
      win[6]   <= win[7];
      win[7]   <= win[8];
      win[8]   <= s1_pix;
      s2_flags <= s1_flags;
    end
  end

  // ---------------------------------------------------------------- partial sums
  // Zero the taps that fall outside the frame
  always_comb begin
    logic row_ok;
    logic col_ok;
    for (int k = 0; k < 9; k++) begin
      row_ok = 1'b1;
      col_ok = 1'b1;
      if (k < 3) begin
        row_ok = s2_flags.top_ok;
      end else if (k >= 6) begin
        row_ok = s2_flags.bot_ok;
      end
      if (k == 0 || k == 3 || k == 6) begin
        col_ok = s2_flags.left_ok;
      end else if (k == 2 || k == 5 || k == 8) begin
        col_ok = s2_flags.right_ok;
      end
      win_m[k] = win[k] & {PW{row_ok && col_ok}};
    end
  end

  assign sum_corner = 10'(win_m[0]) + 10'(win_m[2]) + 10'(win_m[6]) + 10'(win_m[8]);
  assign sum_edge   = 10'(win_m[1]) + 10'(win_m[3]) + 10'(win_m[5]) + 10'(win_m[7]);

  // Scharr: sum = 3*a + 10*b, with a and b picked by direction
  always_comb begin
    case (filter_mode)
      c3zp_pkg::MODE_SCHARR_V: begin
        sum_a = 11'(win_m[0]) + 11'(win_m[2]) - 11'(win_m[6]) - 11'(win_m[8]);
        sum_b = 10'(win_m[1]) - 10'(win_m[7]);
      end
      default: begin
        sum_a = 11'(win_m[0]) - 11'(win_m[2]) + 11'(win_m[6]) - 11'(win_m[8]);
        sum_b = 10'(win_m[3]) - 10'(win_m[5]);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_en && s2_valid) begin
      s3_corner <= sum_corner;
      s3_edge   <= sum_edge;
      s3_centre <= win_m[4];
      s3_a      <= sum_a;
      s3_b      <= sum_b;
      s3_last   <= s2_flags.last;
    end
  end

  // ---------------------------------------------------------------- result
  assign sa_x = {{2{s3_a[10]}}, s3_a};
  assign sb_x = {{3{s3_b[9]}}, s3_b};
  assign ssum = sa_x + (sa_x <<< 1) + (sb_x <<< 3) + (sb_x <<< 1);

  // Clamp Scharr to 0..255
  always_comb begin
    if (ssum[12]) begin
      scharr_pix = '0;
    end else if (ssum > 13'sd255) begin
      scharr_pix = 8'd255;
    end else begin
      scharr_pix = ssum[PW-1:0];
    end
  end

  // Gaussian: weighted sum, round half up, saturate
  assign gsum = ACC_W'(s3_corner) * W_CORNER + ACC_W'(s3_edge) * W_EDGE +
                ACC_W'(s3_centre) * W_CENTRE + ROUND_HALF;
  assign gq   = gsum[ACC_W-1:COEF_FRAC_BITS];
  assign gauss_pix = (gq > 10'd255) ? 8'd255 : gq[PW-1:0];

  always_comb begin
    case (filter_mode) inside
      c3zp_pkg::MODE_SCHARR_H, c3zp_pkg::MODE_SCHARR_V: res_pix = scharr_pix;
      default:                                          res_pix = gauss_pix;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s3_valid) begin
      out_pixel <= res_pix;
      out_last  <= s3_last;
    end
  end

  assign results.valid         = out_valid;
  assign results.out_pixel     = out_pixel;
  assign results.last_of_frame = out_last;

  // ---------------------------------------------------------------- assertions
  `C3ZP_ASSERT_IMPLIES(a_ready_when_out_empty, clk, rst, !out_valid, pixels.ready,
    "input not ready although the output register is empty")
  `C3ZP_ASSERT_NEXT(a_last_restarts_frame, clk, rst,
    in_acc && !in_drop && pos_flags.last, in_row == '0 && in_col == '0,
    "frame position not restarted after the last output")
  `C3ZP_ASSERT_NEXT(a_drop_holds_position, clk, rst, in_acc && in_drop && !cfg_wr,
    $stable(in_row) && $stable(in_col), "dropped flush moved the frame position")

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking bench for conv3x3_zero_pad_filter: drives pixel frames and register writes,
// predicts every filtered pixel and compares it with what the block returns.
// Depends on c3zp_pkg, the channel interfaces in c3zp_intf.sv and the filter RTL.
module testbench;

  localparam logic [c3zp_pkg::MODE_W-1:0]    MODE_SPARE  = 2'd3; // unlisted mode, Gaussian
  localparam logic [c3zp_pkg::CFG_IDX_W-1:0] CFG_SPARE   = 2'd3; // no register behind it
  localparam int                             STUCK_LIMIT = 2000;
  localparam int                             IDLE_PAUSE  = 16;
  localparam int                             HOLD_OFF    = 300;
  localparam int                             ITEM_TARGET = 1030; // directed items included

  typedef struct packed {
    logic [c3zp_pkg::PIXEL_W-1:0] value;
    logic                         last;
  } filtered_t;

  // Bit-true model of the filter plus the queue of outputs it still owes
  class conv3x3_board;
    logic [c3zp_pkg::MODE_W-1:0]  mode;
    logic [c3zp_pkg::DIM_W-1:0]   width_reg;
    logic [c3zp_pkg::DIM_W-1:0]   height_reg;
    logic [c3zp_pkg::PIXEL_W-1:0] upper_row [c3zp_pkg::MAX_WIDTH_DEF];
    logic [c3zp_pkg::PIXEL_W-1:0] middle_row [c3zp_pkg::MAX_WIDTH_DEF];
    logic [c3zp_pkg::PIXEL_W-1:0] win [9];
    logic [c3zp_pkg::DIM_W-1:0]   row;
    logic [c3zp_pkg::DIM_W-1:0]   col;
    longint unsigned              gauss_w [9];
    int                           scharr_h [9] = '{3, 0, -3, 10, 0, -10, 3, 0, -3};
    int                           scharr_v [9] = '{3, 10, 3, 0, 0, 0, -3, -10, -3};
    int                           failures;
    filtered_t                    due_pixels [$];

    function new();
      longint unsigned micro;
      mode       = c3zp_pkg::MODE_GAUSS;
      width_reg  = c3zp_pkg::DIM_RESET;
      height_reg = c3zp_pkg::DIM_RESET;
      row        = '0;
      col        = '0;
      failures   = 0;
      foreach (upper_row[i]) begin
        upper_row[i]  = '0;
        middle_row[i] = '0;
      end
      // Round the weights to the fixed-point grid once
      foreach (win[k]) begin
        win[k] = '0;
        if (k == 4) begin
          micro = c3zp_pkg::GAUSS_MICRO_CENTRE;
        end else if (k % 2 == 1) begin
          micro = c3zp_pkg::GAUSS_MICRO_EDGE;
        end else begin
          micro = c3zp_pkg::GAUSS_MICRO_CORNER;
        end
        gauss_w[k] = ((micro << c3zp_pkg::COEF_FRAC_BITS_DEF) + c3zp_pkg::MICRO_SCALE / 2)
                     / c3zp_pkg::MICRO_SCALE;
      end
    endfunction

    // Zero acts as one, oversize acts as the maximum
    function int unsigned size_in_use(logic [c3zp_pkg::DIM_W-1:0] v, int unsigned maxv);
      if (v == '0) return 1;
      if (int'(v) > maxv) return maxv;
      return v;
    endfunction

    function int unsigned frame_w();
      return size_in_use(width_reg, c3zp_pkg::MAX_WIDTH_DEF);
    endfunction

    function int unsigned frame_h();
      return size_in_use(height_reg, c3zp_pkg::MAX_HEIGHT_DEF);
    endfunction

    function void write_register(logic [c3zp_pkg::CFG_IDX_W-1:0] idx,
                                 logic [c3zp_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        c3zp_pkg::CFG_MODE: mode = data[c3zp_pkg::MODE_W-1:0];
        c3zp_pkg::CFG_WIDTH: begin
          width_reg = data;
          row = '0;
          col = '0;
        end
        c3zp_pkg::CFG_HEIGHT: begin
          height_reg = data;
          row = '0;
          col = '0;
        end
        default: ;
      endcase
    endfunction

    // Advance the model by one accepted item and queue the output it completes
    function void accept_input(logic [c3zp_pkg::PIXEL_W-1:0] px, logic fl);
      int unsigned                  w, h, r, c;
      int                           cr, cc, pr, pc, ssum;
      bit                           is_pixel, emit, scharr;
      logic [c3zp_pkg::PIXEL_W-1:0] v, top, mid;
      longint unsigned              gsum, q;
      filtered_t                    res;
      w = frame_w();
      h = frame_h();
      r = row;
      c = col;
      is_pixel = (r * w + c) < (h * w);
      // Drop a flush inside the frame
      if (is_pixel && fl) return;
      v = is_pixel ? px : '0;
      top = '0;
      mid = '0;
      if (c < c3zp_pkg::MAX_WIDTH_DEF) begin
        top = upper_row[c];
        mid = middle_row[c];
        upper_row[c]  = mid;
        middle_row[c] = v;
      end
      for (int i = 0; i < 3; i++) begin
        win[i * 3]     = win[i * 3 + 1];
        win[i * 3 + 1] = win[i * 3 + 2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = v;

      emit = (r >= 2) || (r == 1 && c >= 1);
      if (c >= 1) begin
        cr = int'(r) - 1;
        cc = int'(c) - 1;
      end else begin
        cr = int'(r) - 2;
        cc = int'(w) - 1;
      end
      c++;
      if (c >= w) begin
        c = 0;
        r++;
      end
      row = r[c3zp_pkg::DIM_W-1:0];
      col = c[c3zp_pkg::DIM_W-1:0];
      if (!emit) return;

      // Correlate the window, taps outside the frame read zero
      gsum = 0;
      ssum = 0;
      scharr = (mode == c3zp_pkg::MODE_SCHARR_H) || (mode == c3zp_pkg::MODE_SCHARR_V);
      for (int k = 0; k < 9; k++) begin
        pr = cr + k / 3 - 1;
        pc = cc + k % 3 - 1;
        if (pr >= 0 && pr < int'(h) && pc >= 0 && pc < int'(w)) begin
          case (mode)
            c3zp_pkg::MODE_SCHARR_H: ssum += scharr_h[k] * int'(win[k]);
            c3zp_pkg::MODE_SCHARR_V: ssum += scharr_v[k] * int'(win[k]);
            default:                 gsum += gauss_w[k] * longint'(win[k]);
          endcase
        end
      end
      if (scharr) begin
        res.value = (ssum < 0) ? 8'd0 : ((ssum > 255) ? 8'd255 : ssum[7:0]);
      end else begin
        q = (gsum + (64'd1 << (c3zp_pkg::COEF_FRAC_BITS_DEF - 1)))
            >> c3zp_pkg::COEF_FRAC_BITS_DEF;
        res.value = (q > 255) ? 8'd255 : q[7:0];
      end
      res.last = (cr == int'(h) - 1) && (cc == int'(w) - 1);
      if (res.last) begin
        row = '0;
        col = '0;
      end
      due_pixels.push_back(res);
    endfunction

    function void compare_output(logic [c3zp_pkg::PIXEL_W-1:0] value, logic last);
      filtered_t want;
      if (due_pixels.size() == 0) begin
        $display("%0t: output with none due: out_pixel %0d last_of_frame %0b", $time, value,
                 last);
        failures++;
        return;
      end
      want = due_pixels.pop_front();
      if (value !== want.value) begin
        $display("%0t: out_pixel expected %0d, actual %0d", $time, want.value, value);
        failures++;
      end
      if (last !== want.last) begin
        $display("%0t: last_of_frame expected %0b, actual %0b", $time, want.last, last);
        failures++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  c3zp_cfg_if    cfg_ch ();
  c3zp_pixel_if  pix_ch ();
  c3zp_result_if res_ch ();

  conv3x3_zero_pad_filter uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .pixels  (pix_ch),
    .results (res_ch)
  );

  conv3x3_board board = new();
  int           sent_items   = 0;
  int           holds_asked  = 0;
  int           holds_served = 0;
  int           stuck_cycles = 0;
  bit           sender_gaps  = 1'b1;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Sample all channels at the falling edge, where everything has settled
  always @(negedge clk) begin
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) board.write_register(cfg_ch.index, cfg_ch.data);
      if (res_ch.valid && res_ch.ready)
        board.compare_output(res_ch.out_pixel, res_ch.last_of_frame);
      if (pix_ch.valid && pix_ch.ready) board.accept_input(pix_ch.pixel, pix_ch.flush);
    end
  end

  // End the run when no transfer happens for too long
  always @(negedge clk) begin
    if (!rst) begin
      if ((cfg_ch.valid && cfg_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (pix_ch.valid && pix_ch.ready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
          $display("%0t: no transfer for %0d cycles", $time, STUCK_LIMIT);
          $display("testbench NOT OK");
          $finish;
        end
      end
    end
  end

  // Output side: random ready pattern, plus long hold-offs on request
  initial begin
    int seg;
    bit rdy;
    seg = 0;
    rdy = 1'b0;
    res_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served < holds_asked) begin
        holds_served++;
        rdy = 1'b0;
        res_ch.ready <= 1'b0;
        repeat (HOLD_OFF) @(posedge clk);
        seg = 0;
      end else if (seg > 0) begin
        seg--;
      end else begin
        rdy = !rdy;
        if (rdy) begin
          seg = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 20);
        end else begin
          seg = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(0, 2);
        end
        res_ch.ready <= rdy;
      end
    end
  end

  function automatic logic [c3zp_pkg::PIXEL_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Offer one item and hold it until the transfer; ends on the transfer edge
  task automatic send_item(input logic [c3zp_pkg::PIXEL_W-1:0] px, input logic fl);
    int unsigned gap, roll;
    gap = 0;
    if (sender_gaps) begin
      roll = $urandom_range(0, 99);
      if (roll >= 95) gap = $urandom_range(10, 40);
      else if (roll >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    pix_ch.flush <= fl;
    @(negedge clk);
    while (!pix_ch.ready) @(negedge clk);
    @(posedge clk);
    sent_items++;
  endtask

  task automatic write_reg(input logic [c3zp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [c3zp_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(negedge clk);
    while (!cfg_ch.ready) @(negedge clk);
    @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop offering, wait for every due output, then let the pipeline empty
  task automatic settle();
    pix_ch.valid <= 1'b0;
    while (board.due_pixels.size() > 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  // width+1 drain items; a noisy drain mixes in pixels, which count as flushes
  task automatic send_drain(input bit noisy);
    int unsigned n;
    n = board.frame_w() + 1;
    repeat (n) begin
      if (noisy && $urandom_range(0, 4) == 0) send_item(8'($urandom), 1'b0);
      else send_item(8'($urandom), 1'b1);
    end
  endtask

  task automatic send_frame(input bit noisy);
    int unsigned n;
    n = board.frame_w() * board.frame_h();
    for (int unsigned i = 0; i < n; i++) begin
      // stray flush inside the frame, dropped by the block
      if (noisy && $urandom_range(0, 19) == 0) send_item(8'($urandom), 1'b1);
      send_item(pick_pixel(), 1'b0);
    end
    send_drain(noisy);
  endtask

  task automatic random_phase();
    int unsigned pick, frames;
    settle();
    sender_gaps = ($urandom_range(0, 3) != 0);
    write_reg(c3zp_pkg::CFG_MODE, {9'($urandom), 2'($urandom)});
    pick = $urandom_range(0, 19);
    write_reg(c3zp_pkg::CFG_WIDTH, (pick == 0) ? 11'd0 :
              ((pick == 1) ? 11'($urandom_range(17, 48)) : 11'($urandom_range(1, 12))));
    pick = $urandom_range(0, 19);
    write_reg(c3zp_pkg::CFG_HEIGHT, (pick == 0) ? 11'd0 : 11'($urandom_range(1, 6)));
    if ($urandom_range(0, 19) == 0) write_reg(CFG_SPARE, 11'($urandom));
    frames = $urandom_range(1, 2);
    repeat (frames) begin
      if ($urandom_range(0, 9) == 0) begin
        // cut the frame short; the next dimension write restarts it
        repeat ($urandom_range(1, board.frame_w() * board.frame_h())) begin
          send_item(pick_pixel(), 1'b0);
        end
        return;
      end
      send_frame($urandom_range(0, 3) == 0);
    end
  endtask

  initial begin
    rst          = 1'b1;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    pix_ch.flush = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = c3zp_pkg::CFG_MODE;
    cfg_ch.data  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset size: a few pixels of the top row, a dropped flush, no output
    send_item(8'd0, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'hA5, 1'b1);
    send_item(8'd1, 1'b0);
    settle();

    // Gaussian on a flat white 2x2 frame
    write_reg(c3zp_pkg::CFG_MODE, {9'h1FF, c3zp_pkg::MODE_GAUSS});
    write_reg(c3zp_pkg::CFG_WIDTH, 11'd2);
    write_reg(c3zp_pkg::CFG_HEIGHT, 11'd2);
    repeat (4) send_item(8'd255, 1'b0);
    send_drain(1'b0);
    settle();

    // Horizontal Scharr: saturates high; flush in frame, pixel in drain
    write_reg(c3zp_pkg::CFG_MODE, {9'h000, c3zp_pkg::MODE_SCHARR_H});
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'h5A, 1'b1);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'h77, 1'b0);
    send_item(8'd0, 1'b1);
    send_item(8'd0, 1'b1);
    settle();

    // Vertical Scharr across a white-over-black edge
    write_reg(c3zp_pkg::CFG_MODE, {9'h0AA, c3zp_pkg::MODE_SCHARR_V});
    send_item(8'd255, 1'b0);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd0, 1'b0);
    send_drain(1'b0);
    settle();

    // Spare mode, zero dimensions acting as 1x1, write to the unused index
    write_reg(c3zp_pkg::CFG_MODE, {9'h1FF, MODE_SPARE});
    write_reg(c3zp_pkg::CFG_WIDTH, 11'd0);
    write_reg(c3zp_pkg::CFG_HEIGHT, 11'd0);
    write_reg(CFG_SPARE, 11'h7FF);
    send_item(8'd128, 1'b0);
    send_drain(1'b0);
    settle();

    // Back-pressure: hold the output off while pixels keep coming, filling the block
    sender_gaps = 1'b0;
    write_reg(c3zp_pkg::CFG_MODE, {9'($urandom), c3zp_pkg::MODE_SCHARR_V});
    write_reg(c3zp_pkg::CFG_WIDTH, 11'd16);
    write_reg(c3zp_pkg::CFG_HEIGHT, 11'd16);
    holds_asked++;
    send_frame(1'b0);

    // Random frames, mostly well formed
    while (sent_items < ITEM_TARGET) random_phase();

    settle();
    if (board.failures == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
